/* sv/sps_pkg.sv */
// Shared types and constants for the SoC power state sequencer.
`default_nettype none

package sps_pkg;

  // Configuration port geometry.
  localparam int unsigned CFG_W  = 16;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned ADDR_W = 3;

  // Register word indexes, taken from paddr[2].
  localparam logic REG_S5_WAIT_LIMIT = 1'b0;
  localparam logic REG_PWROK_DELAY   = 1'b1;

  // Register reset values.
  localparam logic [CFG_W-1:0] S5_WAIT_LIMIT_RST = 16'd1000;
  localparam logic [CFG_W-1:0] PWROK_DELAY_RST   = 16'd1;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_G3   = 4'd0,
    ST_G3S5 = 4'd1,
    ST_S5   = 4'd2,
    ST_S5S3 = 4'd3,
    ST_S3   = 4'd4,
    ST_S3S0 = 4'd5,
    ST_S0   = 4'd6,
    ST_S0S3 = 4'd7,
    ST_S3S5 = 4'd8,
    ST_S5G3 = 4'd9
  } seq_state_t;

  // Hook events reported with each result.
  typedef enum logic [2:0] {
    EV_NONE     = 3'd0,
    EV_STARTUP  = 3'd1,
    EV_RESUME   = 3'd2,
    EV_SUSPEND  = 3'd3,
    EV_SHUTDOWN = 3'd4,
    EV_HARD_OFF = 3'd5
  } event_t;

  // Wireless power modes.
  typedef enum logic [1:0] {
    WL_OFF     = 2'd0,
    WL_SUSPEND = 2'd1,
    WL_ON      = 2'd2
  } wireless_t;

  // One sampled tick.
  typedef struct packed {
    logic s5_good;
    logic s0_good;
    logic slp_s5_n;
    logic slp_s3_n;
    logic power_on_request;
    logic shutdown_request;
    logic link_reset_seen;
  } sample_t;

  // Sequencer levels that persist from tick to tick.
  typedef struct packed {
    seq_state_t seq;
    logic       forcing;
    logic       rsmrst;
    logic       pwrok;
    logic       rail;
    wireless_t  wireless;
    logic       sleep_ok;
  } pwr_state_t;

  localparam pwr_state_t PWR_STATE_RST = '{
    seq:      ST_G3,
    forcing:  1'b0,
    rsmrst:   1'b0,
    pwrok:    1'b0,
    rail:     1'b0,
    wireless: WL_OFF,
    sleep_ok: 1'b1
  };

  // Off states ignore a forced shutdown request.
  function automatic logic is_off(input seq_state_t s);
    return (s == ST_G3) || (s == ST_G3S5) || (s == ST_S5) || (s == ST_S5G3);
  endfunction

endpackage

`default_nettype wire

/* sv/sps_cfg_regs.sv */
// APB-style configuration registers for the power state sequencer.
`default_nettype none

module sps_cfg_regs (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [sps_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [sps_pkg::DATA_W-1:0]  pwdata,
  output logic      [sps_pkg::DATA_W-1:0]  prdata,
  output logic      [sps_pkg::CFG_W-1:0]   s5_wait_limit,
  output logic      [sps_pkg::CFG_W-1:0]   pwrok_delay
);
  import sps_pkg::*;

  logic wr_en;

  // A write completes in the access phase; the port never waits.
  assign wr_en = psel && penable && pwrite;

  // Register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      s5_wait_limit <= S5_WAIT_LIMIT_RST;
      pwrok_delay   <= PWROK_DELAY_RST;
    end else if (wr_en) begin
      unique case (paddr[2])
        REG_S5_WAIT_LIMIT: s5_wait_limit <= pwdata[CFG_W-1:0];
        REG_PWROK_DELAY:   pwrok_delay   <= pwdata[CFG_W-1:0];
        default:           ;
      endcase
    end
  end

  // Read data mux.
  always_comb begin
    unique case (paddr[2])
      REG_S5_WAIT_LIMIT: prdata = DATA_W'(s5_wait_limit);
      REG_PWROK_DELAY:   prdata = DATA_W'(pwrok_delay);
      default:           prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

/* sv/sps_step.sv */
// Next-state logic of the power sequencer for one sampled tick.
`default_nettype none

module sps_step #(
  parameter int unsigned COUNT_BITS = 16
) (
  input  wire sps_pkg::pwr_state_t     cur,
  input  wire logic [COUNT_BITS-1:0]   s5_cnt,
  input  wire logic [COUNT_BITS-1:0]   pw_cnt,
  input  wire sps_pkg::sample_t        smp,
  input  wire logic [sps_pkg::CFG_W-1:0] s5_wait_limit,
  input  wire logic [sps_pkg::CFG_W-1:0] pwrok_delay,
  output sps_pkg::pwr_state_t          nxt,
  output logic      [COUNT_BITS-1:0]   s5_cnt_next,
  output logic      [COUNT_BITS-1:0]   pw_cnt_next,
  output sps_pkg::event_t              ev
);
  import sps_pkg::*;

  // Compare width covers both the counters and the 16-bit registers.
  localparam int unsigned CW = (COUNT_BITS > CFG_W) ? COUNT_BITS : CFG_W;
  typedef logic [CW-1:0] cw_t;

  logic                  tgt;
  logic [COUNT_BITS-1:0] pw_inc;
  logic [COUNT_BITS-1:0] s5_inc;
  logic [CFG_W-1:0]      lim;
  logic                  pw_done;
  logic                  s5_timeout;

  // Saturating increments and the threshold compares.
  assign tgt        = smp.s0_good && smp.s5_good;
  assign pw_inc     = (pw_cnt == '1) ? pw_cnt : pw_cnt + 1'b1;
  assign s5_inc     = (s5_cnt == '1) ? s5_cnt : s5_cnt + 1'b1;
  assign lim        = (s5_wait_limit == '0) ? CFG_W'(1) : s5_wait_limit;
  assign pw_done    = cw_t'(pw_cnt) >= cw_t'(pwrok_delay);
  assign s5_timeout = cw_t'(s5_inc) >= cw_t'(lim);

  always_comb begin
    nxt         = cur;
    s5_cnt_next = s5_cnt;
    pw_cnt_next = pw_cnt;
    ev          = EV_NONE;

    // RSMRST follows S5 good; PWROK rises after the delay, drops at once.
    nxt.rsmrst = smp.s5_good;
    if (!tgt) begin
      nxt.pwrok   = 1'b0;
      pw_cnt_next = '0;
    end else if (!cur.pwrok) begin
      if (pw_done) begin
        nxt.pwrok   = 1'b1;
        pw_cnt_next = '0;
      end else begin
        pw_cnt_next = pw_inc;
      end
    end

    // Forced shutdown press: set when on, released by link reset with S5 good, or in S5.
    if (smp.shutdown_request && !is_off(cur.seq)) begin
      nxt.forcing = 1'b1;
    end
    if (smp.link_reset_seen && smp.s5_good) begin
      nxt.forcing = 1'b0;
    end
    if (cur.seq == ST_S5) begin
      nxt.forcing = 1'b0;
    end

    // Sequencer transition.
    unique case (cur.seq)
      ST_G3: begin
        if (smp.power_on_request) nxt.seq = ST_G3S5;
      end
      ST_G3S5: begin
        nxt.rail = 1'b1;
        if (smp.s5_good) begin
          s5_cnt_next = '0;
          nxt.seq     = ST_S5;
        end else if (s5_timeout) begin
          s5_cnt_next = '0;
          nxt.rail    = 1'b0;
          ev          = EV_HARD_OFF;
          nxt.seq     = ST_G3;
        end else begin
          s5_cnt_next = s5_inc;
        end
      end
      ST_S5: begin
        if (!smp.s5_good)      nxt.seq = ST_S5G3;
        else if (smp.slp_s5_n) nxt.seq = ST_S5S3;
      end
      ST_S5S3: begin
        if (!smp.s5_good) begin
          nxt.seq = ST_S5G3;
        end else begin
          ev      = EV_STARTUP;
          nxt.seq = ST_S3;
        end
      end
      ST_S3: begin
        if (!smp.s5_good)       nxt.seq = ST_S5G3;
        else if (smp.slp_s3_n)  nxt.seq = ST_S3S0;
        else if (!smp.slp_s5_n) nxt.seq = ST_S3S5;
      end
      ST_S3S0: begin
        if (!smp.s5_good) begin
          nxt.seq = ST_S5G3;
        end else begin
          nxt.wireless = WL_ON;
          ev           = EV_RESUME;
          nxt.sleep_ok = 1'b0;
          nxt.seq      = ST_S0;
        end
      end
      ST_S0: begin
        if (!smp.s5_good)       nxt.seq = ST_S5G3;
        else if (!smp.slp_s3_n) nxt.seq = ST_S0S3;
      end
      ST_S0S3: begin
        ev           = EV_SUSPEND;
        nxt.wireless = WL_SUSPEND;
        nxt.sleep_ok = 1'b1;
        nxt.seq      = ST_S3;
      end
      ST_S3S5: begin
        ev           = EV_SHUTDOWN;
        nxt.wireless = WL_OFF;
        nxt.seq      = ST_S5;
      end
      ST_S5G3: begin
        nxt.rail = 1'b0;
        nxt.seq  = ST_G3;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

/* sv/soc_power_state_sequencer.sv */
// Top level of the SoC power state sequencer: input register, state, result register.
//
//   Channel   Handshake                     Payload
//   ------    ----------------------------  -----------------------------------------
//   input     in_valid / in_stall           s5_good .. link_reset_seen (1 bit each)
//   result    out_valid / out_stall         seq_state_out .. deep_sleep_ok
//   config    psel/penable/pwrite/pready    paddr[2:0], pwdata/prdata 32 bits
//
// Each tick passes through the combinational step logic between the input register and
// the result register; a new tick can be taken every cycle while the result is not stalled.
// Sequencer state and counters update as a tick moves into the result register.
// A stalled result holds and the input register takes one more tick behind it.
// Synchronous reset puts the sequencer in G3 with both registers empty.
`default_nettype none

module soc_power_state_sequencer #(
  parameter int unsigned COUNT_BITS = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  // Input channel
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic                        s5_good,
  input  wire logic                        s0_good,
  input  wire logic                        slp_s5_n,
  input  wire logic                        slp_s3_n,
  input  wire logic                        power_on_request,
  input  wire logic                        shutdown_request,
  input  wire logic                        link_reset_seen,
  // Result channel
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic      [3:0]                  seq_state_out,
  output logic                             rail_enable_out,
  output logic                             rsmrst_out,
  output logic                             pwrok_out,
  output logic                             button_press_out,
  output logic      [2:0]                  event_code,
  output logic      [1:0]                  wireless_mode,
  output logic                             deep_sleep_ok,
  // Configuration port
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [sps_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [sps_pkg::DATA_W-1:0]  pwdata,
  output logic      [sps_pkg::DATA_W-1:0]  prdata,
  output logic                             pready
);
  import sps_pkg::*;

  logic [CFG_W-1:0]      s5_wait_limit;
  logic [CFG_W-1:0]      pwrok_delay;

  logic                  in_full;
  sample_t               smp;
  logic                  in_take;
  logic                  advance;

  pwr_state_t            pstate;
  pwr_state_t            pstate_next;
  logic [COUNT_BITS-1:0] s5_cnt;
  logic [COUNT_BITS-1:0] s5_cnt_next;
  logic [COUNT_BITS-1:0] pw_cnt;
  logic [COUNT_BITS-1:0] pw_cnt_next;
  event_t                ev_next;

  pwr_state_t            res;
  event_t                res_ev;

  assign pready = 1'b1;

  sps_cfg_regs u_cfg (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .s5_wait_limit (s5_wait_limit),
    .pwrok_delay   (pwrok_delay)
  );

  // Handshake: a tick moves on when the result register is free or draining.
  assign advance  = in_full && (!out_valid || !out_stall);
  assign in_stall = in_full && !advance;
  assign in_take  = in_valid && !in_stall;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_take) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      smp <= '{
        s5_good:          s5_good,
        s0_good:          s0_good,
        slp_s5_n:         slp_s5_n,
        slp_s3_n:         slp_s3_n,
        power_on_request: power_on_request,
        shutdown_request: shutdown_request,
        link_reset_seen:  link_reset_seen
      };
    end
  end

  sps_step #(
    .COUNT_BITS (COUNT_BITS)
  ) u_step (
    .cur           (pstate),
    .s5_cnt        (s5_cnt),
    .pw_cnt        (pw_cnt),
    .smp           (smp),
    .s5_wait_limit (s5_wait_limit),
    .pwrok_delay   (pwrok_delay),
    .nxt           (pstate_next),
    .s5_cnt_next   (s5_cnt_next),
    .pw_cnt_next   (pw_cnt_next),
    .ev            (ev_next)
  );

  // Sequencer state and counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      pstate <= PWR_STATE_RST;
      s5_cnt <= '0;
      pw_cnt <= '0;
    end else if (advance) begin
      pstate <= pstate_next;
      s5_cnt <= s5_cnt_next;
      pw_cnt <= pw_cnt_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res    <= pstate_next;
      res_ev <= ev_next;
    end
  end

  // Result fields.
  assign seq_state_out    = res.seq;
  assign rail_enable_out  = res.rail;
  assign rsmrst_out       = res.rsmrst;
  assign pwrok_out        = res.pwrok;
  assign button_press_out = res.forcing;
  assign event_code       = res_ev;
  assign wireless_mode    = res.wireless;
  assign deep_sleep_ok    = res.sleep_ok;

endmodule

`default_nettype wire
